// ----- hdl/thpc_pkg.sv -----
// Shared constants, types and register codes of the tile half-plane cull block.
package thpc_pkg;

	// Sizing
	localparam int MAX_PLANES  = 6;
	localparam int COORD_WIDTH = 24;

	// Plane word layout: a, b, d from the low bits up
	localparam int COEF_W  = 21;
	localparam int A_LSB   = 0;
	localparam int B_LSB   = 21;
	localparam int D_LSB   = 42;
	localparam int PLANE_W = 63;

	// a*x carries 27 fraction bits, d carries 3: align d by this shift
	localparam int D_SHIFT = 24;

	localparam int PROD_W = COEF_W + COORD_WIDTH;
	localparam int DSC_W  = COEF_W + D_SHIFT;
	localparam int SUM_W  = ((PROD_W > DSC_W) ? PROD_W : DSC_W) + 2;

	// Payload widths
	localparam int FIRST_W = 24;
	localparam int COUNT_W = 9;
	localparam int PC_W    = 3;

	// Register indexes
	localparam int REG_CULL_ALL    = 0;
	localparam int REG_PLANE_COUNT = 1;
	localparam int REG_PLANE_0     = 2;
	localparam int REG_NUM         = REG_PLANE_0 + MAX_PLANES;

	localparam int CFG_IDX_W  = $clog2(REG_NUM);
	localparam int CFG_DATA_W = PLANE_W;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] min_x;
		logic signed [COORD_WIDTH-1:0] min_z;
		logic signed [COORD_WIDTH-1:0] max_x;
		logic signed [COORD_WIDTH-1:0] max_z;
	} box_t;

	typedef logic [MAX_PLANES-1:0][PLANE_W-1:0] plane_arr_t;

	typedef struct packed {
		logic            cull_all;
		logic [PC_W-1:0] plane_count;
		plane_arr_t      planes;
	} cfg_t;

endpackage

// ----- hdl/thpc_if.sv -----
// Valid/ready channel interfaces for tiles in and draw commands out.
interface thpc_tile_if import thpc_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] tile_min_x;
	logic signed [COORD_WIDTH-1:0] tile_min_z;
	logic signed [COORD_WIDTH-1:0] tile_max_x;
	logic signed [COORD_WIDTH-1:0] tile_max_z;
	logic        [FIRST_W-1:0]     index_base;
	logic        [COUNT_W-1:0]     index_len;

	modport source (
		output valid, tile_min_x, tile_min_z, tile_max_x, tile_max_z,
		output index_base, index_len,
		input  ready
	);
	modport sink (
		input  valid, tile_min_x, tile_min_z, tile_max_x, tile_max_z,
		input  index_base, index_len,
		output ready
	);
endinterface

interface thpc_draw_if import thpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIRST_W-1:0] draw_first_index;
	logic [COUNT_W-1:0] draw_index_count;

	modport source (
		output valid, draw_first_index, draw_index_count,
		input  ready
	);
	modport sink (
		input  valid, draw_first_index, draw_index_count,
		output ready
	);
endinterface

// ----- hdl/thpc_cfg.sv -----
// Configuration register file: cull_all, plane_count and the plane words.
module thpc_cfg import thpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic            cull_all_q;
	logic [PC_W-1:0] plane_count_q;
	plane_arr_t      planes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_all_q    <= 1'b0;
			plane_count_q <= '0;
			planes_q      <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDX_W'(REG_CULL_ALL)) begin
				cull_all_q <= cfg_data[0];
			end
			if (cfg_index == CFG_IDX_W'(REG_PLANE_COUNT)) begin
				plane_count_q <= cfg_data[PC_W-1:0];
			end
			for (int k = 0; k < MAX_PLANES; k++) begin
				if (cfg_index == CFG_IDX_W'(REG_PLANE_0 + k)) begin
					planes_q[k] <= cfg_data[PLANE_W-1:0];
				end
			end
		end
	end

	assign cfg.cull_all    = cull_all_q;
	assign cfg.plane_count = plane_count_q;
	assign cfg.planes      = planes_q;

endmodule

// ----- hdl/thpc_plane_eval.sv -----
// One half-plane: registered corner products, then the all-behind sign test.
module thpc_plane_eval import thpc_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [PLANE_W-1:0] plane,
	input  box_t               box,
	output logic               behind
);

	logic signed [COEF_W-1:0] a;
	logic signed [COEF_W-1:0] b;
	logic signed [COEF_W-1:0] d;

	logic signed [PROD_W-1:0] ax0_s2, ax1_s2, bz0_s2, bz1_s2;
	logic signed [SUM_W-1:0]  d_ext;
	logic signed [SUM_W-1:0]  s00, s10, s01, s11;

	assign a = $signed(plane[A_LSB +: COEF_W]);
	assign b = $signed(plane[B_LSB +: COEF_W]);
	assign d = $signed(plane[D_LSB +: COEF_W]);

	// Products are exact at PROD_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			ax0_s2 <= PROD_W'(a) * PROD_W'(box.min_x);
			ax1_s2 <= PROD_W'(a) * PROD_W'(box.max_x);
			bz0_s2 <= PROD_W'(b) * PROD_W'(box.min_z);
			bz1_s2 <= PROD_W'(b) * PROD_W'(box.max_z);
		end
	end

	assign d_ext = SUM_W'(d) <<< D_SHIFT;

	assign s00 = SUM_W'(ax0_s2) + SUM_W'(bz0_s2) + d_ext;
	assign s10 = SUM_W'(ax1_s2) + SUM_W'(bz0_s2) + d_ext;
	assign s01 = SUM_W'(ax0_s2) + SUM_W'(bz1_s2) + d_ext;
	assign s11 = SUM_W'(ax1_s2) + SUM_W'(bz1_s2) + d_ext;

	// Strictly negative at all four corners
	assign behind = s00[SUM_W-1] & s10[SUM_W-1] & s01[SUM_W-1] & s11[SUM_W-1];

endmodule

// ----- hdl/tile_half_plane_cull.sv -----
// Top level of the tile half-plane cull block: pipeline, drop logic and draw output.
// Pipeline: a tile passes the input register, the product register and the output register,
//   in that order, before it raises draw valid; its draw transfer follows when draw ready is seen.
// Throughput: one tile per cycle while the draw output is not stalled; the 21x24 corner multipliers of
//   each plane sit in their own stage, so only a three-input add and the sign test follow them.
// Reset: arst_n clears all pipeline valid bits, the draw output valid and every
//   configuration register (cull_all, plane_count, plane words) to zero.
module tile_half_plane_cull import thpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	thpc_tile_if.sink             tile,
	thpc_draw_if.source           draw,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;

	// Stage 1: captured tile
	logic               valid_s1;
	box_t               box_s1;
	logic [FIRST_W-1:0] index_base_s1;
	logic [COUNT_W-1:0] index_len_s1;

	// Stage 2: products held inside each plane unit, payload here
	logic               valid_s2;
	logic [FIRST_W-1:0] index_base_s2;
	logic [COUNT_W-1:0] index_len_s2;

	// Output register
	logic               draw_valid_q;
	logic [FIRST_W-1:0] draw_first_index_q;
	logic [COUNT_W-1:0] draw_index_count_q;

	logic                  adv1;
	logic                  adv2;
	logic                  drop_s2;
	logic [MAX_PLANES-1:0] behind;
	logic [MAX_PLANES-1:0] active;

	thpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance: the output register frees when empty or taken; each stage moves
	// when the one after it moves or is empty. A full pipe keeps moving under
	// continuous draw transfers.
	assign adv2       = !draw_valid_q || draw.ready;
	assign adv1       = !valid_s2 || adv2;
	assign tile.ready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tile.ready) begin
			valid_s1 <= tile.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tile.valid && tile.ready) begin
			box_s1.min_x  <= tile.tile_min_x;
			box_s1.min_z  <= tile.tile_min_z;
			box_s1.max_x  <= tile.tile_max_x;
			box_s1.max_z  <= tile.tile_max_z;
			index_base_s1 <= tile.index_base;
			index_len_s1  <= tile.index_len;
		end
	end

	// One plane unit per configured plane slot; planes at or above
	// plane_count are masked off, which also clamps counts above MAX_PLANES.
	for (genvar k = 0; k < MAX_PLANES; k++) begin : g_plane
		thpc_plane_eval u_plane (
			.clk    (clk),
			.en     (adv1 && valid_s1),
			.plane  (cfg.planes[k]),
			.box    (box_s1),
			.behind (behind[k])
		);
		assign active[k] = PC_W'(k) < cfg.plane_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && valid_s1) begin
			index_base_s2 <= index_base_s1;
			index_len_s2  <= index_len_s1;
		end
	end

	// Drop the tile when culling everything or when any active plane has all
	// four corners behind it.
	assign drop_s2 = cfg.cull_all || ((behind & active) != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_valid_q <= 1'b0;
		end else if (adv2) begin
			draw_valid_q <= valid_s2 && !drop_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s2 && !drop_s2) begin
			draw_first_index_q <= index_base_s2;
			draw_index_count_q <= index_len_s2;
		end
	end

	assign draw.valid            = draw_valid_q;
	assign draw.draw_first_index = draw_first_index_q;
	assign draw.draw_index_count = draw_index_count_q;

`ifndef ASSERT_OFF
	a_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		tile.valid && tile.ready |=> valid_s1)
		else $error("transferred tile not captured in stage 1");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv1 |=> valid_s1 && $stable(index_base_s1))
		else $error("stalled stage 1 tile lost or changed");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && adv2 && !drop_s2 |=>
			draw_valid_q && draw_first_index_q == $past(index_base_s2))
		else $error("visible tile did not reach the draw output");

	a_cull: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && !(valid_s2 && !drop_s2) |=> !draw_valid_q)
		else $error("draw command appeared without a visible tile");
`endif

endmodule
